### design/dcs_pkg.sv
`timescale 1ns / 1ps
package dcs_pkg;

    // configuration port
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_ROW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTES  = 3'd7;

    // request kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // command queue depth
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // bin arithmetic: 50 mm bins, reciprocal of 50 scaled by 2^21
    localparam logic [15:0] BIN_MM     = 16'd50;
    localparam logic [15:0] BIN_RECIP  = 16'd41944;
    localparam logic [15:0] RANGE_SAT  = 16'd16383;
    localparam logic [8:0]  VOTE_SAT   = 9'd511;

    typedef enum logic [1:0] {
        OP_VOTE,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        logic [16:0] center_row;
        logic [17:0] focal_row;
        logic [11:0] mount;
        logic [11:0] band_low;
        logic [11:0] band_high;
        logic [13:0] near_limit;
        logic [13:0] far_limit;
        logic [8:0]  min_votes;
    } t_cfg;

    typedef struct packed {
        t_op        op;
        logic       col_ok;
        logic [9:0] col;
        logic [8:0] row;
        logic [9:0] bin;
    } t_cmd;

    // round(mm / 50), exact for mm below 16384
    function automatic logic [8:0] to_bin(input logic [13:0] mm);
        logic [14:0] x;
        logic [31:0] prod;
        x    = {1'b0, mm} + 15'd25;
        prod = 32'(x) * 32'(BIN_RECIP);
        return prod[29:21];
    endfunction

endpackage

### design/dcs_queue.sv
`timescale 1ns / 1ps
module dcs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dcs_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output dcs_pkg::t_cmd o_head
);
    import dcs_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // store requests in arrival order
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/dcs_front.sv
`timescale 1ns / 1ps
module dcs_front #(
    parameter int ROWS    = 480,
    parameter int COLUMNS = 640,
    parameter int BINS    = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_kind,
    input  logic [8:0]    i_row,
    input  logic [9:0]    i_column,
    input  logic [15:0]   i_depth_mm,
    input  dcs_pkg::t_cfg i_cfg,
    input  logic          i_booting,
    output logic          o_push,
    output dcs_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import dcs_pkg::*;

    typedef enum logic {
        F_IDLE,
        F_PUSH
    } t_fstate;

    t_fstate            r_state;
    logic [1:0]         r_kind;
    logic [8:0]         r_row;
    logic [9:0]         r_col;
    logic signed [34:0] r_p;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;
    logic               r_gate;
    logic [9:0]         r_bin;

    logic               accept;
    logic signed [17:0] diff;
    logic signed [12:0] d_lo;
    logic signed [12:0] d_hi;
    logic signed [34:0] n_p;
    logic signed [31:0] n_lo;
    logic signed [31:0] n_hi;
    logic [13:0]        clamped;
    logic [8:0]         raw_bin;
    logic [9:0]         n_bin;
    logic               n_gate;
    logic               vote;
    logic               need;

    assign o_stall = (r_state != F_IDLE) || i_booting;
    assign accept  = i_valid && !o_stall;

    // height test operands and bin of the clamped depth
    always_comb begin
        diff = $signed({1'b0, i_cfg.center_row}) - $signed({1'b0, i_row, 8'd0});
        d_lo = $signed({1'b0, i_cfg.band_low}) - $signed({1'b0, i_cfg.mount});
        d_hi = $signed({1'b0, i_cfg.band_high}) - $signed({1'b0, i_cfg.mount});
        n_p  = 35'(diff) * 35'($signed({1'b0, i_depth_mm}));
        n_lo = 32'($signed({1'b0, i_cfg.focal_row})) * 32'(d_lo);
        n_hi = 32'($signed({1'b0, i_cfg.focal_row})) * 32'(d_hi);
        if (i_depth_mm > {2'b0, i_cfg.far_limit}) begin
            clamped = i_cfg.far_limit;
        end else begin
            clamped = i_depth_mm[13:0];
        end
        raw_bin = to_bin(clamped);
        if ({1'b0, raw_bin} > 10'(BINS - 1)) begin
            n_bin = 10'(BINS - 1);
        end else begin
            n_bin = {1'b0, raw_bin};
        end
        n_gate = (i_row < ROWS) && (i_column < COLUMNS) && (i_cfg.focal_row != '0)
                 && (i_depth_mm >= {2'b0, i_cfg.near_limit}) && (clamped != '0);
    end

    // classify the held request
    always_comb begin
        vote = (r_kind == KIND_PIXEL) && r_gate && (r_p > r_lo) && (r_p < r_hi)
               && (r_p != '0);
        need = vote || (r_kind == KIND_READ) || (r_kind == KIND_CLEAR);
        o_push = (r_state == F_PUSH) && need && !i_full;
        case (r_kind)
            KIND_READ:  o_cmd.op = OP_READ;
            KIND_CLEAR: o_cmd.op = OP_CLEAR;
            default:    o_cmd.op = OP_VOTE;
        endcase
        o_cmd.col_ok = (r_col < COLUMNS);
        o_cmd.col    = r_col;
        o_cmd.row    = r_row;
        o_cmd.bin    = r_bin;
    end

    // hold one request until it is queued or dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!need || !i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
        if (accept) begin
            r_kind <= i_kind;
            r_row  <= i_row;
            r_col  <= i_column;
            r_p    <= n_p;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_gate <= n_gate;
            r_bin  <= n_bin;
        end
    end

endmodule

### design/dcs_back.sv
`timescale 1ns / 1ps
module dcs_back #(
    parameter int COLUMNS = 640,
    parameter int BINS    = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  dcs_pkg::t_cmd i_head,
    output logic          o_pop,
    input  dcs_pkg::t_cfg i_cfg,
    output logic          o_booting,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [9:0]    o_column_out,
    output logic [13:0]   o_range_mm,
    output logic [8:0]    o_votes,
    output logic          o_used_default
);
    import dcs_pkg::*;

    localparam int DEPTH = COLUMNS * BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(BINS);

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_VOTE,
        B_SCAN,
        B_OUT
    } t_bstate;

    logic [17:0]   r_mem [DEPTH];
    logic [17:0]   r_rdata;

    t_bstate       r_state;
    logic          r_booting;
    logic [AW-1:0] r_caddr;
    logic [AW-1:0] r_vaddr;
    logic [8:0]    r_vrow;
    logic [AW-1:0] r_base;
    logic [BW:0]   r_iss;
    logic          r_rv;
    logic [BW-1:0] r_cb;
    logic [8:0]    r_bv;
    logic [BW-1:0] r_bb;
    logic [8:0]    r_br;
    logic [9:0]    r_col;
    logic          r_ovalid;

    logic          we;
    logic [AW-1:0] waddr;
    logic [17:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [AW-1:0] head_base;
    logic [AW-1:0] head_vaddr;
    logic [8:0]    v;
    logic [8:0]    fr;
    logic          hit;
    logic          deflt;
    logic [8:0]    dbin_raw;
    logic [9:0]    dbin;
    logic [9:0]    sel_bin;
    logic [15:0]   mm;
    logic          load;

    assign o_booting = r_booting;
    assign o_valid   = r_ovalid;
    assign o_pop     = (r_state == B_IDLE) && !i_empty;
    assign head_base = AW'(i_head.col) * AW'(BINS);
    assign head_vaddr = head_base + AW'(i_head.bin);
    assign v  = r_rdata[17:9];
    assign fr = r_rdata[8:0];
    assign hit = (v != '0) && ((v > r_bv) || ((v == r_bv) && (fr < r_br)));
    assign load = (r_state == B_OUT) && (!r_ovalid || !i_stall);

    // memory port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_caddr;
        wdata = '0;
        re    = 1'b0;
        raddr = head_vaddr;
        case (r_state)
            B_CLEAR: begin
                we = 1'b1;
            end
            B_IDLE: begin
                if (!i_empty && (i_head.op == OP_VOTE)) begin
                    re = 1'b1;
                end else if (!i_empty && (i_head.op == OP_READ) && i_head.col_ok) begin
                    re    = 1'b1;
                    raddr = head_base;
                end
            end
            B_VOTE: begin
                we    = 1'b1;
                waddr = r_vaddr;
                wdata[17:9] = (v == VOTE_SAT) ? VOTE_SAT : v + 1'b1;
                wdata[8:0]  = (v == '0) ? r_vrow : fr;
            end
            B_SCAN: begin
                if (r_iss < (BW+1)'(BINS)) begin
                    re    = 1'b1;
                    raddr = r_base + AW'(r_iss);
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // histogram store: votes over first-vote row
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // result fields of a finished read
    always_comb begin
        deflt    = (r_bv == '0) || (r_bv < i_cfg.min_votes);
        dbin_raw = to_bin(i_cfg.far_limit);
        if ({1'b0, dbin_raw} > 10'(BINS - 1)) begin
            dbin = 10'(BINS - 1);
        end else begin
            dbin = {1'b0, dbin_raw};
        end
        sel_bin = deflt ? dbin : 10'(r_bb);
        mm      = 16'(sel_bin) * BIN_MM;
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLEAR;
            r_booting <= 1'b1;
            r_caddr   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_ovalid <= load || (r_ovalid && i_stall);
            case (r_state)
                B_CLEAR: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (r_caddr == AW'(DEPTH - 1)) begin
                        r_state   <= B_IDLE;
                        r_booting <= 1'b0;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_col <= i_head.col;
                        r_bv  <= '0;
                        r_bb  <= '0;
                        r_br  <= '0;
                        case (i_head.op)
                            OP_VOTE: begin
                                r_vaddr <= head_vaddr;
                                r_vrow  <= i_head.row;
                                r_state <= B_VOTE;
                            end
                            OP_READ: begin
                                if (i_head.col_ok) begin
                                    r_base  <= head_base;
                                    r_iss   <= (BW+1)'(1);
                                    r_rv    <= 1'b1;
                                    r_cb    <= '0;
                                    r_state <= B_SCAN;
                                end else begin
                                    r_state <= B_OUT;
                                end
                            end
                            OP_CLEAR: begin
                                r_caddr <= '0;
                                r_state <= B_CLEAR;
                            end
                            default: r_state <= B_IDLE;
                        endcase
                    end
                end
                B_VOTE: begin
                    r_state <= B_IDLE;
                end
                B_SCAN: begin
                    if (r_rv && hit) begin
                        r_bv <= v;
                        r_bb <= r_cb;
                        r_br <= fr;
                    end
                    if (r_iss < (BW+1)'(BINS)) begin
                        r_iss <= r_iss + 1'b1;
                        r_rv  <= 1'b1;
                        r_cb  <= r_iss[BW-1:0];
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (!r_rv) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
        if (load) begin
            o_column_out   <= r_col;
            o_range_mm     <= (mm > RANGE_SAT) ? RANGE_SAT[13:0] : mm[13:0];
            o_votes        <= r_bv;
            o_used_default <= deflt;
        end
    end

endmodule

### design/depth_column_to_scan_mode.sv
`timescale 1ns / 1ps
// Depth image to range scan by per-column histogram mode.
// Input channel (i_valid / o_stall) carries requests: a pixel vote with row,
// column and depth, a column read, or a clear of every histogram. Output
// channel (o_valid / i_stall) returns one scan value per column read.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must do this only while the block is idle (the block does not enforce it).
// Flow: the front stage holds one request at a time (multiply, then compare
// and queue) and takes no new one until the held one is queued or dropped.
// In the back, a pixel vote reads, then writes the counter; a column read
// scans one histogram entry per cycle from the single memory port; and a
// clear sweeps all COLUMNS * BINS entries, one entry per cycle (163840 at
// default size). The back takes a new request only after finishing the last.
// A four-entry queue sits between front and back.
// Reset: registers return to their defaults and the histogram memory is
// swept to zero, all COLUMNS * BINS entries, with o_stall high throughout.
// When the receiver stalls, the result is held in the output register; the
// back waits with its next result, and requests pile up in the queue until
// o_stall rises.
module depth_column_to_scan_mode #(
    parameter int COLUMNS = 640,
    parameter int ROWS    = 480,
    parameter int BINS    = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_kind,
    input  logic [8:0]                     i_row,
    input  logic [9:0]                     i_column,
    input  logic [15:0]                    i_depth_mm,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [9:0]                     o_column_out,
    output logic [13:0]                    o_range_mm,
    output logic [8:0]                     o_votes,
    output logic                           o_used_default,
    input  logic                           i_cfg_we,
    input  logic [dcs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dcs_pkg::CFG_W-1:0]      i_cfg_data
);
    import dcs_pkg::*;

    t_cfg r_cfg;
    logic booting;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd cmd;
    t_cmd head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_row <= 17'd61842;
            r_cfg.focal_row  <= 18'd98384;
            r_cfg.mount      <= 12'd410;
            r_cfg.band_low   <= 12'd700;
            r_cfg.band_high  <= 12'd900;
            r_cfg.near_limit <= 14'd450;
            r_cfg.far_limit  <= 14'd7000;
            r_cfg.min_votes  <= 9'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_ROW: r_cfg.center_row <= i_cfg_data[16:0];
                CFG_FOCAL_ROW:  r_cfg.focal_row  <= i_cfg_data;
                CFG_MOUNT:      r_cfg.mount      <= i_cfg_data[11:0];
                CFG_BAND_LOW:   r_cfg.band_low   <= i_cfg_data[11:0];
                CFG_BAND_HIGH:  r_cfg.band_high  <= i_cfg_data[11:0];
                CFG_RANGE_MIN:  r_cfg.near_limit <= i_cfg_data[13:0];
                CFG_RANGE_MAX:  r_cfg.far_limit  <= i_cfg_data[13:0];
                CFG_MIN_VOTES:  r_cfg.min_votes  <= i_cfg_data[8:0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    dcs_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .BINS    (BINS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_row      (i_row),
        .i_column   (i_column),
        .i_depth_mm (i_depth_mm),
        .i_cfg      (r_cfg),
        .i_booting  (booting),
        .o_push     (push),
        .o_cmd      (cmd),
        .i_full     (full)
    );

    dcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    dcs_back #(
        .COLUMNS (COLUMNS),
        .BINS    (BINS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .i_cfg          (r_cfg),
        .o_booting      (booting),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_column_out   (o_column_out),
        .o_range_mm     (o_range_mm),
        .o_votes        (o_votes),
        .o_used_default (o_used_default)
    );

    // a trusted mode has enough votes
    a_trusted_votes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_used_default |-> (o_votes >= r_cfg.min_votes) && (o_votes != '0))
        else $error("mode reported without enough votes");

    // an empty column always falls back to the default range
    a_empty_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_votes == '0) |-> o_used_default)
        else $error("empty column without default range");

    // the clearing sweep after reset holds off requests
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("request taken during clearing sweep");

endmodule

### test/tb_depth_column_to_scan_mode.sv
`timescale 1ns / 1ps
module tb_depth_column_to_scan_mode;
    import dcs_pkg::*;

    localparam int NCOL      = 640;
    localparam int NROW      = 480;
    localparam int NBIN      = 256;
    localparam int CLEAR_CYC = NCOL * NBIN + 2000;
    localparam int SETTLE    = 1200;
    localparam longint LIMIT = 10_000_000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        bit [9:0]  col;
        bit [13:0] mm;
        bit [8:0]  votes;
        bit        used_def;
    } scan_t;

    // column histogram predictor and store of expected scan values
    class scan_scoreboard;
        bit [16:0] cy;
        bit [17:0] fy;
        bit [11:0] mount, band_lo, band_hi;
        bit [13:0] rng_min, rng_max;
        bit [8:0]  min_votes;
        bit [8:0]  vote_tab[NCOL*NBIN];
        bit [8:0]  first_row_tab[NCOL*NBIN];
        scan_t     scan_q[$];
        int        n_err;
        int        n_scans;

        function new();
            cy = 17'd61842; fy = 18'd98384; mount = 12'd410;
            band_lo = 12'd700; band_hi = 12'd900;
            rng_min = 14'd450; rng_max = 14'd7000; min_votes = 9'd4;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [17:0] val);
            case (idx)
                CFG_CENTER_ROW: cy        = val[16:0];
                CFG_FOCAL_ROW:  fy        = val[17:0];
                CFG_MOUNT:      mount     = val[11:0];
                CFG_BAND_LOW:   band_lo   = val[11:0];
                CFG_BAND_HIGH:  band_hi   = val[11:0];
                CFG_RANGE_MIN:  rng_min   = val[13:0];
                CFG_RANGE_MAX:  rng_max   = val[13:0];
                CFG_MIN_VOTES:  min_votes = val[8:0];
                default: ;
            endcase
        endfunction

        function int bin_of(int mm);
            int b;
            b = (mm + 25) / 50;
            return (b > NBIN - 1) ? NBIN - 1 : b;
        endfunction

        function void note_request(bit [1:0] kind, bit [8:0] row, bit [9:0] col,
                                   bit [15:0] depth);
            longint p, lo, hi;
            int     r, idx, best_v, best_b, best_r, mm;
            scan_t  s;
            if (kind == KIND_PIXEL) begin
                if (row >= NROW || col >= NCOL || fy == 0) return;
                p  = (longint'(cy) - longint'(row) * 256) * longint'(depth);
                lo = longint'(fy) * (longint'(band_lo) - longint'(mount));
                hi = longint'(fy) * (longint'(band_hi) - longint'(mount));
                if (!(p > lo && p < hi && p != 0)) return;
                r = int'(depth);
                if (r < rng_min) return;
                if (r > rng_max) r = int'(rng_max);
                if (r == 0) return;
                idx = col * NBIN + bin_of(r);
                if (vote_tab[idx] == 0) first_row_tab[idx] = row;
                if (vote_tab[idx] < 511) vote_tab[idx]++;
            end else if (kind == KIND_READ) begin
                best_v = 0; best_b = 0; best_r = 0;
                if (col < NCOL) begin
                    for (int b = 0; b < NBIN; b++) begin
                        idx = col * NBIN + b;
                        if (vote_tab[idx] == 0) continue;
                        if (vote_tab[idx] > best_v ||
                            (vote_tab[idx] == best_v && first_row_tab[idx] < best_r)) begin
                            best_v = int'(vote_tab[idx]);
                            best_b = b;
                            best_r = int'(first_row_tab[idx]);
                        end
                    end
                end
                s.used_def = (best_v == 0) || (best_v < min_votes);
                if (s.used_def) best_b = bin_of(int'(rng_max));
                mm = best_b * 50;
                if (mm > 16383) mm = 16383;
                s.col   = col;
                s.mm    = mm[13:0];
                s.votes = best_v[8:0];
                scan_q = {scan_q, s};
            end else if (kind == KIND_CLEAR) begin
                foreach (vote_tab[i]) vote_tab[i] = '0;
            end
        endfunction

        function void check_scan(bit [9:0] col, bit [13:0] mm, bit [8:0] votes, bit ud);
            scan_t s;
            if (scan_q.size() == 0) begin
                $error("scan value for column %0d with none expected", col);
                n_err++;
                return;
            end
            s = scan_q.pop_front();
            n_scans++;
            if (col != s.col) begin
                $error("column_out: expected %0d, got %0d", s.col, col); n_err++;
            end
            if (mm != s.mm) begin
                $error("range_mm: expected %0d, got %0d", s.mm, mm); n_err++;
            end
            if (votes != s.votes) begin
                $error("votes: expected %0d, got %0d", s.votes, votes); n_err++;
            end
            if (ud != s.used_def) begin
                $error("used_default: expected %0d, got %0d", s.used_def, ud); n_err++;
            end
        endfunction
    endclass

    logic                 i_clk, i_rst_n;
    logic                 i_valid, o_stall;
    logic [1:0]           i_kind;
    logic [8:0]           i_row;
    logic [9:0]           i_column;
    logic [15:0]          i_depth_mm;
    logic                 o_valid, i_stall;
    logic [9:0]           o_column_out;
    logic [13:0]          o_range_mm;
    logic [8:0]           o_votes;
    logic                 o_used_default;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    scan_scoreboard sb = new();

    bit     tx_steady, rx_steady, hold_req, clear_sent;
    int     n_requests, n_settings;
    longint cycles;
    bit [9:0]  hot_col[4];
    int        base_depth[4];

    depth_column_to_scan_mode DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver: random stall, quiet stretch, or one long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (rx_steady) begin
                i_stall = 1'b0;
            end else begin
                i_stall = ($urandom_range(99) < 28);
            end
        end
    end

    // check every accepted scan value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_scan(o_column_out, o_range_mm, o_votes, o_used_default);
    end

    // offer one request; entered and left at a falling edge
    task automatic offer(bit [1:0] kind, bit [8:0] row, bit [9:0] col, bit [15:0] depth);
        if (!tx_steady && $urandom_range(99) < 28) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_kind     = kind;
        i_row      = row;
        i_column   = col;
        i_depth_mm = depth;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(kind, row, col, depth);
        n_requests++;
        if (kind == KIND_CLEAR) clear_sent = 1'b1;
        @(negedge i_clk);
    endtask

    // drain results, then let the back end finish silent work
    task automatic quiesce();
        i_valid = 1'b0;
        while (sb.scan_q.size() != 0) @(negedge i_clk);
        repeat (clear_sent ? CLEAR_CYC : SETTLE) @(negedge i_clk);
        clear_sent = 1'b0;
    endtask

    task automatic write_cfg(int v0, int v1, int v2, int v3, int v4, int v5, int v6, int v7);
        int vals[8];
        vals = '{v0, v1, v2, v3, v4, v5, v6, v7};
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   = 1'b1;
            i_cfg_idx  = k[CFG_IDX_W-1:0];
            i_cfg_data = vals[k][CFG_W-1:0];
            sb.set_reg(k[CFG_IDX_W-1:0], vals[k][17:0]);
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
        n_settings++;
    endtask

    // random requests: mostly aimed votes on a few columns, some reads, some noise
    task automatic run_random(int items, int rlo, int rhi, int dlo, int dhi);
        int r, k, d;
        hot_col[0] = 10'd0;
        hot_col[1] = 10'd639;
        hot_col[2] = 10'($urandom_range(1, 638));
        hot_col[3] = 10'($urandom_range(1, 638));
        foreach (base_depth[j]) base_depth[j] = $urandom_range(dlo, dhi);
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(99);
            k = $urandom_range(0, 3);
            if (r < 4) begin
                offer(($urandom_range(0, 3) == 0) ? KIND_UNUSED : KIND_PIXEL,
                      9'($urandom_range(0, 511)), 10'($urandom_range(0, 1023)),
                      16'($urandom_range(0, 65535)));
            end else if (r < 12) begin
                offer(KIND_READ, 9'd0,
                      ($urandom_range(9) < 8) ? hot_col[k] : 10'($urandom_range(0, 1023)),
                      16'd0);
            end else begin
                if ($urandom_range(9) < 6) d = base_depth[k] + $urandom_range(0, 120) - 60;
                else d = $urandom_range(dlo, dhi);
                if (d < 0) d = 0;
                offer(KIND_PIXEL, 9'($urandom_range(rlo, rhi)), hot_col[k], d[15:0]);
            end
        end
        for (int j = 0; j < 4; j++) offer(KIND_READ, 9'd0, hot_col[j], 16'd0);
    endtask

    initial begin
        i_rst_n = 1'b0;  i_valid = 1'b0;  i_kind = KIND_PIXEL;
        i_row = '0;  i_column = '0;  i_depth_mm = '0;
        i_cfg_we = 1'b0;  i_cfg_idx = '0;  i_cfg_data = '0;
        tx_steady = 1'b0;  rx_steady = 1'b0;  hold_req = 1'b0;  clear_sent = 1'b0;
        n_requests = 0;  n_settings = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset settings: extremes, ignored items, tie on first row
        offer(KIND_PIXEL, 9'd0, 10'd0, 16'd0);
        offer(KIND_PIXEL, 9'd479, 10'd639, 16'hFFFF);
        offer(KIND_PIXEL, 9'd100, 10'd5, 16'd1000);
        offer(KIND_PIXEL, 9'd100, 10'd5, 16'd1000);
        offer(KIND_PIXEL, 9'd95, 10'd7, 16'd1000);
        offer(KIND_PIXEL, 9'd90, 10'd7, 16'd1100);
        offer(KIND_PIXEL, 9'd480, 10'd5, 16'd1000);
        offer(KIND_PIXEL, 9'd511, 10'd1023, 16'd1000);
        offer(KIND_PIXEL, 9'd100, 10'd640, 16'd1000);
        offer(KIND_PIXEL, 9'd100, 10'd5, 16'd300);
        offer(KIND_UNUSED, 9'd511, 10'd1023, 16'hFFFF);
        offer(KIND_READ, 9'd0, 10'd7, 16'd0);
        offer(KIND_READ, 9'd0, 10'd5, 16'd0);
        offer(KIND_READ, 9'd0, 10'd640, 16'd0);
        offer(KIND_READ, 9'd0, 10'd1023, 16'd0);
        offer(KIND_CLEAR, 9'd0, 10'd0, 16'd0);
        offer(KIND_READ, 9'd0, 10'd5, 16'd0);
        quiesce();

        // wide band, camera level at row 240; saturate one counter, no idling
        write_cfg(240*256, 500*256, 0, 0, 4095, 300, 9000, 1);
        tx_steady = 1'b1;
        repeat (515) offer(KIND_PIXEL, 9'd10, 10'd3, 16'd2000);
        offer(KIND_READ, 9'd0, 10'd3, 16'd0);
        tx_steady = 1'b0;
        run_random(150, 0, 239, 300, 9500);

        // long receiver hold-off while reads pile up
        hold_req = 1'b1;
        repeat (10) offer(KIND_READ, 9'd0, 10'($urandom_range(0, 639)), 16'd0);
        offer(KIND_CLEAR, 9'd0, 10'd0, 16'd0);
        run_random(150, 0, 239, 300, 9500);
        quiesce();

        // reset values again, receiver never stalls
        write_cfg(61842, 98384, 410, 700, 900, 450, 7000, 4);
        rx_steady = 1'b1;
        run_random(200, 90, 110, 900, 1200);
        rx_steady = 1'b0;
        quiesce();

        // upper extremes: nothing can count
        write_cfg(131071, 262143, 4095, 0, 4095, 0, 12750, 480);
        run_random(120, 0, 479, 0, 65535);
        quiesce();

        // lower extremes: only tiny depths near row 1 vote, bin zero
        write_cfg(0, 1, 4095, 0, 4095, 0, 12750, 1);
        run_random(300, 1, 3, 1, 15);
        quiesce();

        // zero focal length and zero maximum range
        write_cfg($urandom_range(0, 131071), 0, $urandom_range(0, 4095), 0, 4095,
                  0, 0, $urandom_range(1, 480));
        run_random(80, 0, 479, 0, 65535);
        quiesce();

        // random settings with a wide band
        repeat (2) begin
            write_cfg($urandom_range(200, 300) * 256, $urandom_range(300, 700) * 256,
                      $urandom_range(0, 200), $urandom_range(0, 100),
                      $urandom_range(3000, 4095), $urandom_range(0, 1000),
                      $urandom_range(4000, 12750), $urandom_range(1, 8));
            run_random(100, 0, 479, 200, 13000);
            quiesce();
        end

        repeat (600) @(negedge i_clk);
        $display("Requests accepted: %0d, scan values checked: %0d, settings applied: %0d",
                 n_requests, sb.n_scans, n_settings);
        if (sb.n_err == 0 && sb.scan_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("Mismatches: %0d, scan values still outstanding: %0d",
                     sb.n_err, sb.scan_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
design/dcs_pkg.sv
design/dcs_queue.sv
design/dcs_front.sv
design/dcs_back.sv
design/depth_column_to_scan_mode.sv
test/tb_depth_column_to_scan_mode.sv
